>>> rtl/core/sleep_table_wakeup_timer_defines.svh
// Assertion macros shared by the sleep table RTL.
`ifndef SLEEP_TABLE_WAKEUP_TIMER_DEFINES_SVH
`define SLEEP_TABLE_WAKEUP_TIMER_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define STWT_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define STWT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/core/stwt_pkg.sv
`default_nettype none

package stwt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int THREAD_W = 8;
    localparam int UNITS_W  = 16;
    localparam int TPU_W    = 16;
    localparam int TICK_W   = 32;
    localparam int KIND_W   = 2;

    localparam logic [TPU_W-1:0]  TPU_RESET = TPU_W'(100);
    localparam logic [TICK_W-1:0] TICK_MAX  = '1;

    // machine_idle value that marks idle mode
    localparam logic IDLE_MODE = 1'b1;

    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        RK_ACCEPTED = 2'd0,
        RK_FULL     = 2'd1,
        RK_WOKEN    = 2'd2,
        RK_DONE     = 2'd3
    } t_result_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SLEEP,
        S_FULL,
        S_TREAD,
        S_TEVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [TICK_W-1:0]   wake;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/core/stwt_if.sv
`default_nettype none

// Request channel: sleep requests and tick scans.
interface stwt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [stwt_pkg::THREAD_W-1:0] thread_id;
    logic [stwt_pkg::UNITS_W-1:0]  sleep_units;
    logic [stwt_pkg::TICK_W-1:0]   current_tick;
    logic                          machine_idle;

    modport source (output valid, opcode, thread_id, sleep_units, current_tick,
                    machine_idle, input ready);
    modport sink (input valid, opcode, thread_id, sleep_units, current_tick,
                  machine_idle, output ready);
endinterface

// Result channel.
interface stwt_out_if;
    logic                          valid;
    logic                          ready;
    logic [stwt_pkg::KIND_W-1:0]   result_kind;
    logic [stwt_pkg::THREAD_W-1:0] woken_thread;
    logic [stwt_pkg::TICK_W-1:0]   wake_tick;
    logic                          yield_hint;
    logic                          last_result;

    modport source (output valid, result_kind, woken_thread, wake_tick, yield_hint,
                    last_result, input ready);
    modport sink (input valid, result_kind, woken_thread, wake_tick, yield_hint,
                  last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sleep_table_wakeup_timer.sv
// Channel    Dir  Transaction                   Ports
// ---------  ---  ----------------------------  ---------------------------------
// request    in   sleep request or tick scan    i_in  (valid/ready + payload)
// result     out  accepted/full/woken/done      o_out (valid/ready + payload)
// config     in   ticks_per_unit write          i_cfg_wr_en, i_cfg_wr_data
//
// Steps: sleep request: accept, multiply, table write; table full: accept, result;
//   tick scan: accept, then one table read and one evaluate/write-back step per
//   occupied entry on the single table memory, then the done result.
// Reset: synchronous, active low; clears the entry count, the FSM and the output
//   valid, and loads ticks_per_unit with 100. Table contents are not cleared.
// Stalls: a result sits in the output register until taken; the FSM holds in
//   its emitting state while that register is still occupied.
`default_nettype none

`include "sleep_table_wakeup_timer_defines.svh"

module sleep_table_wakeup_timer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [stwt_pkg::TPU_W-1:0]  i_cfg_wr_data,
    stwt_in_if.sink                          i_in,
    stwt_out_if.source                       o_out
);

    localparam int IDX_W  = stwt_pkg::IDX_W;
    localparam int CNT_W  = stwt_pkg::CNT_W;
    localparam int TICK_W = stwt_pkg::TICK_W;

    // Control state
    stwt_pkg::t_state          r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [stwt_pkg::TPU_W-1:0] r_tpu;

    // Captured request payload
    logic [stwt_pkg::THREAD_W-1:0] r_thread;
    logic [stwt_pkg::UNITS_W-1:0]  r_units;
    logic [TICK_W-1:0]             r_now;
    logic                          r_idle;
    logic [TICK_W-1:0]             r_prod;

    // Table memory and its registered read data
    stwt_pkg::t_entry r_table [stwt_pkg::TABLE_DEPTH];
    stwt_pkg::t_entry r_rd_cur;
    stwt_pkg::t_entry r_rd_last;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    stwt_pkg::t_entry mem_wdata;
    logic             rd_en;

    // Output register
    logic                          r_out_valid;
    stwt_pkg::t_result_kind        r_out_kind, n_out_kind;
    logic [stwt_pkg::THREAD_W-1:0] r_out_thread, n_out_thread;
    logic [TICK_W-1:0]             r_out_wake, n_out_wake;
    logic                          r_out_yield, n_out_yield;
    logic                          r_out_last, n_out_last;
    logic                          out_load;
    logic                          out_free;

    logic                          in_fire;
    logic [CNT_W-1:0]              cnt_m1;
    logic [IDX_W-1:0]              last_idx;
    logic [TICK_W:0]               wake_sum;
    logic [TICK_W-1:0]             wake_sat;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign cnt_m1   = r_count - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];

    // Saturate the wake tick at the tick maximum.
    assign wake_sum = {1'b0, r_now} + {1'b0, r_prod};
    assign wake_sat = wake_sum[TICK_W] ? stwt_pkg::TICK_MAX : wake_sum[TICK_W-1:0];

    assign i_in.ready         = (r_state == stwt_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_out_kind;
    assign o_out.woken_thread = r_out_thread;
    assign o_out.wake_tick    = r_out_wake;
    assign o_out.yield_hint   = r_out_yield;
    assign o_out.last_result  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stwt_pkg::S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_tpu   <= stwt_pkg::TPU_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cfg_wr_en) begin
                r_tpu <= i_cfg_wr_data;
            end
        end
    end

    // Capture the request; the product gets a register of its own before the add.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_thread <= i_in.thread_id;
            r_units  <= i_in.sleep_units;
            r_now    <= i_in.current_tick;
            r_idle   <= i_in.machine_idle;
        end
        if (r_state == stwt_pkg::S_MUL) begin
            r_prod <= TICK_W'(r_units) * TICK_W'(r_tpu);
        end
    end

    // Table: one write port, reads of the scanned entry and the last entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_cur  <= r_table[r_idx];
            r_rd_last <= r_table[last_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind   <= n_out_kind;
            r_out_thread <= n_out_thread;
            r_out_wake   <= n_out_wake;
            r_out_yield  <= n_out_yield;
            r_out_last   <= n_out_last;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_rd_last;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        n_out_kind   = stwt_pkg::RK_DONE;
        n_out_thread = '0;
        n_out_wake   = '0;
        n_out_yield  = 1'b0;
        n_out_last   = 1'b1;

        unique case (r_state)
            stwt_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in.opcode == stwt_pkg::OP_SLEEP) begin
                        if (r_count == CNT_W'(stwt_pkg::TABLE_DEPTH)) begin
                            n_state = stwt_pkg::S_FULL;
                        end else begin
                            n_state = stwt_pkg::S_MUL;
                        end
                    end else if (r_count == '0) begin
                        n_state = stwt_pkg::S_DONE;
                    end else begin
                        // Scan starts at the highest occupied index.
                        n_idx   = last_idx;
                        n_state = stwt_pkg::S_TREAD;
                    end
                end
            end
            stwt_pkg::S_MUL: begin
                n_state = stwt_pkg::S_SLEEP;
            end
            stwt_pkg::S_SLEEP: begin
                if (out_free) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_count[IDX_W-1:0];
                    mem_wdata    = '{thread: r_thread, wake: wake_sat};
                    n_count      = r_count + CNT_W'(1);
                    out_load     = 1'b1;
                    n_out_kind   = stwt_pkg::RK_ACCEPTED;
                    n_out_thread = r_thread;
                    n_out_wake   = wake_sat;
                    n_state      = stwt_pkg::S_IDLE;
                end
            end
            stwt_pkg::S_FULL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = stwt_pkg::RK_FULL;
                    n_state    = stwt_pkg::S_IDLE;
                end
            end
            stwt_pkg::S_TREAD: begin
                rd_en   = 1'b1;
                n_state = stwt_pkg::S_TEVAL;
            end
            stwt_pkg::S_TEVAL: begin
                if (r_now >= r_rd_cur.wake) begin
                    // Hold until the output register frees, then wake and
                    // move the last entry into this slot.
                    if (out_free) begin
                        out_load     = 1'b1;
                        n_out_kind   = stwt_pkg::RK_WOKEN;
                        n_out_thread = r_rd_cur.thread;
                        n_out_wake   = r_rd_cur.wake;
                        n_out_last   = 1'b0;
                        mem_we       = 1'b1;
                        mem_waddr    = r_idx;
                        mem_wdata    = r_rd_last;
                        n_count      = cnt_m1;
                        if (r_idx == '0) begin
                            n_state = stwt_pkg::S_DONE;
                        end else begin
                            n_idx   = r_idx - IDX_W'(1);
                            n_state = stwt_pkg::S_TREAD;
                        end
                    end
                end else if (r_idx == '0) begin
                    n_state = stwt_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    n_state = stwt_pkg::S_TREAD;
                end
            end
            stwt_pkg::S_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_kind  = stwt_pkg::RK_DONE;
                    n_out_yield = (r_idle != stwt_pkg::IDLE_MODE) || (r_count != '0);
                    n_state     = stwt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stwt_pkg::S_IDLE;
            end
        endcase
    end

    // Occupancy never passes the table depth.
    `STWT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(stwt_pkg::TABLE_DEPTH), "entry count above table depth")
    // A table insert only happens with a free slot.
    `STWT_ASSERT_SAME(a_insert_room, i_clk, i_rst_n,
        r_state == stwt_pkg::S_SLEEP && out_free,
        r_count < CNT_W'(stwt_pkg::TABLE_DEPTH), "insert into full table")
    // Each woken result removes exactly one entry.
    `STWT_ASSERT_NEXT(a_wake_removes, i_clk, i_rst_n,
        out_load && n_out_kind == stwt_pkg::RK_WOKEN,
        r_count == $past(r_count) - CNT_W'(1), "woken entry not removed")

endmodule

`default_nettype wire
